>>> design/thcr_pkg.sv
// thcr_pkg: item, result and register types plus fixed codes for the
// touch heat/cool relay controller; no dependencies
package thcr_pkg;

    // counter and field widths
    localparam int CTR_W      = 16;
    localparam int TEMP_W     = 12;
    localparam int DUTY_W     = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CTR_W-1:0]  CTR_MAX   = '1;
    localparam logic [DUTY_W-1:0] FULL_DUTY = '1;

    // result mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COOL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_PER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_TIME   = 3'd3;

    // configuration reset values
    localparam logic signed [TEMP_W-1:0] RST_TARGET_TEMP = 12'sd480;
    localparam logic [DUTY_W-1:0]        RST_HOLD_DUTY   = 8'd147;
    localparam logic [CTR_W-1:0]         RST_CLICK_PER   = 16'd1000;
    localparam logic [CTR_W-1:0]         RST_COOL_TIME   = 16'd60000;

    typedef struct packed {
        logic                     remote_touched;
        logic                     local_touched;
        logic signed [TEMP_W-1:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DUTY_W-1:0] heater_duty;
        logic              cool_relay;
        logic              heat_relay;
    } t_out_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target_temperature;
        logic [DUTY_W-1:0]        hold_duty;
        logic [CTR_W-1:0]         click_period_ms;
        logic [CTR_W-1:0]         cooling_time_ms;
    } t_cfg;

endpackage

>>> design/thcr_ctrl.sv
// thcr_ctrl: relay levels and elapsed counters, computes one tick's result
// depends on thcr_pkg
module thcr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  thcr_pkg::t_in_item  i_item,
    input  thcr_pkg::t_cfg      i_cfg,
    output thcr_pkg::t_out_item o_result
);
    import thcr_pkg::*;

    logic             r_cool_lvl;
    logic             r_heat_lvl;
    logic [CTR_W-1:0] r_click;
    logic [CTR_W-1:0] r_cool;
    logic             n_cool_lvl;
    logic             n_heat_lvl;
    logic [CTR_W-1:0] n_click;
    logic [CTR_W-1:0] n_cool;

    logic [CTR_W-1:0] click_inc;
    logic [CTR_W-1:0] cool_inc;
    logic             agree_lvl;
    logic             toggle;

    // saturating advance of both counters
    assign click_inc = (r_click == CTR_MAX) ? CTR_MAX : r_click + 1'b1;
    assign cool_inc  = (r_cool == CTR_MAX) ? CTR_MAX : r_cool + 1'b1;

    // disagreeing relays drop to off before a possible toggle
    assign agree_lvl = (r_cool_lvl == r_heat_lvl) ? r_cool_lvl : 1'b0;
    assign toggle    = !i_item.local_touched && (click_inc > i_cfg.click_period_ms);

    // next state and result for this tick
    always_comb begin
        o_result = '0;
        n_click  = click_inc;
        n_cool   = cool_inc;
        if (i_item.remote_touched) begin
            n_cool_lvl           = agree_lvl ^ toggle;
            n_heat_lvl           = agree_lvl ^ toggle;
            n_cool               = '0;
            if (toggle) begin
                n_click = '0;
            end
            o_result.mode        = MODE_HEAT;
            o_result.heater_duty = (i_item.temperature < i_cfg.target_temperature)
                                 ? FULL_DUTY : i_cfg.hold_duty;
        end else begin
            n_heat_lvl = 1'b0;
            n_cool_lvl = (cool_inc < i_cfg.cooling_time_ms);
            o_result.mode        = n_cool_lvl ? MODE_COOL : MODE_IDLE;
            o_result.heater_duty = '0;
        end
        o_result.cool_relay = n_cool_lvl;
        o_result.heat_relay = n_heat_lvl;
    end

    // state update once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cool_lvl <= 1'b0;
            r_heat_lvl <= 1'b0;
            r_click    <= '0;
            r_cool     <= CTR_MAX;
        end else if (i_step) begin
            r_cool_lvl <= n_cool_lvl;
            r_heat_lvl <= n_heat_lvl;
            r_click    <= n_click;
            r_cool     <= n_cool;
        end
    end

`ifndef ASSERT_OFF
    // counter may only restart from a processed heat tick
    a_click_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_click == '0 && $past(r_click) != '0 && $past(i_rst_n))
        |-> ($past(i_step) && $past(i_item.remote_touched)))
        else $error("click counter restarted outside a heat tick");
    // a processed heat tick always restarts the cool counter
    a_cool_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.remote_touched) |=> (r_cool == '0))
        else $error("cool counter not restarted by heat tick");
    // relays always agree after a heat tick
    a_heat_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.remote_touched) |=> (r_cool_lvl == r_heat_lvl))
        else $error("relays disagree after heat tick");
`endif

endmodule

>>> design/touch_heat_cool_relay_controller_core.sv
// touch_heat_cool_relay_controller_core: top level with input register,
// result register and configuration registers; depends on thcr_pkg, thcr_ctrl
//
//  channel | direction | handshake                 | payload
//  in      | sink      | i_in_valid / o_in_stall   | i_in_item (t_in_item)
//  out     | source    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per clock while the output is not stalled; each item passes the input
// register, then the single pass through the tick logic, then the result register
// synchronous active-low reset clears relays, counters, valid flags and configuration registers to defaults
// an output stall holds the result and backs up into the input register;
// the input stalls only when that register is full and cannot drain
module touch_heat_cool_relay_controller_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  thcr_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output thcr_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [thcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [thcr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import thcr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;

    logic      out_take;
    logic      step;
    t_out_item result;

    // pipeline handshake
    assign out_take    = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && out_take;
    assign o_in_stall  = r_in_valid && !out_take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temperature <= RST_TARGET_TEMP;
            r_cfg.hold_duty          <= RST_HOLD_DUTY;
            r_cfg.click_period_ms    <= RST_CLICK_PER;
            r_cfg.cooling_time_ms    <= RST_COOL_TIME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_TEMP: r_cfg.target_temperature <= i_cfg_data[TEMP_W-1:0];
                CFG_HOLD_DUTY:   r_cfg.hold_duty          <= i_cfg_data[DUTY_W-1:0];
                CFG_CLICK_PER:   r_cfg.click_period_ms    <= i_cfg_data[CTR_W-1:0];
                CFG_COOL_TIME:   r_cfg.cooling_time_ms    <= i_cfg_data[CTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick logic and controller state
    thcr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

`ifndef ASSERT_OFF
    // heat relay only drives while heating
    a_heat_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.heat_relay) |-> (o_out_item.mode == MODE_HEAT))
        else $error("heat relay on outside heat mode");
    // idle and cooling results carry zero duty
    a_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.mode != MODE_HEAT) |-> (o_out_item.heater_duty == '0))
        else $error("nonzero duty outside heat mode");
    // cooling mode drives the cool relay, idle drives none
    a_cool_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.mode != MODE_HEAT)
        |-> (o_out_item.cool_relay == (o_out_item.mode == MODE_COOL)))
        else $error("cool relay does not match mode");
    // input stalls only with a held item behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without backpressure");
`endif

endmodule

>>> sim/thcr_tick_checker.sv
// thcr_tick_checker: watches the tick, result and register channels of the relay
// controller, predicts each result and compares it; depends on thcr_pkg
module thcr_tick_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  thcr_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  thcr_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [thcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [thcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import thcr_pkg::*;

    // shadow copy of the registers and of the controller state
    t_cfg             settings;
    logic             cool_lvl;
    logic             heat_lvl;
    logic [CTR_W-1:0] click_ms;
    logic [CTR_W-1:0] cool_ms;

    t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        checked_count  = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d, %s: got %0d expected %0d",
                 checked_count, what, got, want);
        mismatch_count++;
    endtask

    // one millisecond tick: counters, relay clicking, duty and mode
    task automatic advance_tick(input t_in_item tick, output t_out_item res);
        logic signed [TEMP_W-1:0] temp;
        logic signed [TEMP_W-1:0] target;
        temp   = tick.temperature;
        target = settings.target_temperature;
        res    = '0;
        if (click_ms != CTR_MAX) click_ms = click_ms + 1'b1;
        if (cool_ms != CTR_MAX) cool_ms = cool_ms + 1'b1;
        if (tick.remote_touched) begin
            res.mode = MODE_HEAT;
            // relays out of step are both dropped first
            if (cool_lvl != heat_lvl) begin
                cool_lvl = 1'b0;
                heat_lvl = 1'b0;
            end
            if (!tick.local_touched && click_ms > settings.click_period_ms) begin
                cool_lvl = ~cool_lvl;
                heat_lvl = ~heat_lvl;
                click_ms = '0;
            end
            res.heater_duty = (temp < target) ? FULL_DUTY : settings.hold_duty;
            cool_ms = '0;
        end else begin
            res.heater_duty = '0;
            heat_lvl = 1'b0;
            if (cool_ms < settings.cooling_time_ms) begin
                res.mode = MODE_COOL;
                cool_lvl = 1'b1;
            end else begin
                res.mode = MODE_IDLE;
                cool_lvl = 1'b0;
            end
        end
        res.cool_relay = cool_lvl;
        res.heat_relay = heat_lvl;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            settings.target_temperature = RST_TARGET_TEMP;
            settings.hold_duty          = RST_HOLD_DUTY;
            settings.click_period_ms    = RST_CLICK_PER;
            settings.cooling_time_ms    = RST_COOL_TIME;
            cool_lvl = 1'b0;
            heat_lvl = 1'b0;
            click_ms = '0;
            cool_ms  = CTR_MAX;
            expected_results.delete();
        end else begin
            // register writes, spare indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET_TEMP: settings.target_temperature = i_cfg_data[TEMP_W-1:0];
                    CFG_HOLD_DUTY:   settings.hold_duty = i_cfg_data[DUTY_W-1:0];
                    CFG_CLICK_PER:   settings.click_period_ms = i_cfg_data[CTR_W-1:0];
                    CFG_COOL_TIME:   settings.cooling_time_ms = i_cfg_data[CTR_W-1:0];
                    default: ;
                endcase
            end
            // compare an accepted result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(got), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.mode != want.mode)
                        report_mismatch("mode", got.mode, want.mode);
                    if (got.heater_duty != want.heater_duty)
                        report_mismatch("heater_duty", got.heater_duty, want.heater_duty);
                    if (got.cool_relay != want.cool_relay)
                        report_mismatch("cool_relay", got.cool_relay, want.cool_relay);
                    if (got.heat_relay != want.heat_relay)
                        report_mismatch("heat_relay", got.heat_relay, want.heat_relay);
                    checked_count++;
                end
            end
            // predict for an accepted tick item
            if (i_in_valid && !i_in_stall) begin
                advance_tick(i_in_item, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
        o_errors  = mismatch_count;
        o_checked = checked_count;
    end

endmodule

>>> sim/tb_top.sv
// tb_top: drives tick items, register writes and output stalls into the relay
// controller core; depends on thcr_pkg, the core and thcr_tick_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import thcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
    localparam int SAT_RUN_TICKS = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 140;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int send_gap_max;
    int stall_max;
    int ticks_sent;
    int reg_writes;
    logic signed [TEMP_W-1:0] cur_target;

    touch_heat_cool_relay_controller_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    thcr_tick_checker relay_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (mismatches),
        .o_pending   (outstanding),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // result side: random stall before each item, then take it
    initial begin : result_sink
        int hold;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            hold = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic t_in_item make_tick(input logic remote, input logic touch_local,
                                           input int temp);
        t_in_item it;
        it.remote_touched = remote;
        it.local_touched  = touch_local;
        it.temperature    = temp[TEMP_W-1:0];
        return it;
    endfunction

    // half the samples sit within a few steps of the target, the rest anywhere
    function automatic int rand_temp();
        int t;
        if ($urandom_range(0, 1) == 1) begin
            t = int'(cur_target) + int'($urandom_range(0, 6)) - 3;
            if (t < -2048) t = -2048;
            if (t > 2047) t = 2047;
        end else begin
            t = int'($urandom_range(0, 4095)) - 2048;
        end
        return t;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(input t_in_item it);
        int gap;
        gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // junk in the upper data bits must be ignored by the narrow registers
    task automatic set_target(input logic signed [TEMP_W-1:0] t);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cur_target = t;
        write_reg(CFG_TARGET_TEMP, {junk[CFG_DATA_W-1:TEMP_W], t});
    endtask

    task automatic set_hold(input logic [DUTY_W-1:0] d);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_HOLD_DUTY, {junk[CFG_DATA_W-1:DUTY_W], d});
    endtask

    // stop sending and let every expected result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial begin : stimulus
        int left;
        int len;
        logic heat;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        send_gap_max = 0;
        stall_max    = 0;
        ticks_sent   = 0;
        reg_writes   = 0;
        cur_target   = RST_TARGET_TEMP;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: saturated cooling counter means idle
        send_tick(make_tick(1'b0, 1'b1, -2048));
        wait_idle();
        // cooling time at maximum still expires on a saturated counter
        write_reg(CFG_COOL_TIME, 16'hFFFF);
        send_tick(make_tick(1'b0, 1'b0, 2047));
        send_tick(make_tick(1'b1, 1'b0, -2048));
        send_tick(make_tick(1'b1, 1'b1, 2047));
        send_tick(make_tick(1'b1, 1'b0, 480));
        send_tick(make_tick(1'b1, 1'b0, 479));
        send_tick(make_tick(1'b0, 1'b0, 0));

        // zero click period, zero cooling time, lowest target and duty
        wait_idle();
        set_target(-12'sd2048);
        set_hold(8'd0);
        write_reg(CFG_CLICK_PER, 16'd0);
        write_reg(CFG_COOL_TIME, 16'd0);
        write_reg(CFG_SPARE_FIRST, 16'hFFFF);
        write_reg(CFG_SPARE_LAST, 16'h0000);
        send_tick(make_tick(1'b1, 1'b0, -2048));
        send_tick(make_tick(1'b1, 1'b0, 100));
        send_tick(make_tick(1'b1, 1'b1, -1));
        send_tick(make_tick(1'b1, 1'b0, 5));
        send_tick(make_tick(1'b0, 1'b1, 7));

        // highest target and duty, short cooling then idle
        wait_idle();
        set_target(12'sd2047);
        set_hold(8'd255);
        write_reg(CFG_COOL_TIME, 16'd3);
        send_tick(make_tick(1'b1, 1'b0, 2046));
        send_tick(make_tick(1'b1, 1'b1, 2047));
        repeat (4) send_tick(make_tick(1'b0, 1'b0, rand_temp()));

        // click period at maximum: a short heat run with no toggle
        wait_idle();
        write_reg(CFG_CLICK_PER, 16'hFFFF);
        repeat (SAT_RUN_TICKS) send_tick(make_tick(1'b1, 1'b0, rand_temp()));
        wait_idle();
        write_reg(CFG_CLICK_PER, 16'd65534);
        send_tick(make_tick(1'b1, 1'b0, rand_temp()));
        send_tick(make_tick(1'b1, 1'b0, rand_temp()));

        // random phases of heat and cool runs under changing settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    set_target(-12'sd2048);
                    set_hold(8'd0);
                    write_reg(CFG_CLICK_PER, 16'd0);
                    write_reg(CFG_COOL_TIME, 16'd0);
                end
                1: begin
                    set_target(12'sd2047);
                    set_hold(8'd255);
                    write_reg(CFG_CLICK_PER, 16'd65534);
                    write_reg(CFG_COOL_TIME, 16'hFFFF);
                end
                default: begin
                    set_target(TEMP_W'($urandom_range(0, 4095)));
                    set_hold(DUTY_W'($urandom_range(0, 255)));
                    write_reg(CFG_CLICK_PER, CTR_W'($urandom_range(0, 30)));
                    write_reg(CFG_COOL_TIME, CTR_W'($urandom_range(0, 40)));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          CFG_DATA_W'($urandom));
            send_gap_max = (p == 0 || $urandom_range(0, 3) != 0) ? 10 : 0;
            stall_max    = (p == 0 || $urandom_range(0, 3) != 0) ? 10 : 0;
            left = PHASE_TICKS;
            while (left > 0) begin
                heat = 1'($urandom_range(0, 1));
                len  = heat ? $urandom_range(1, 40) : $urandom_range(1, 50);
                if (len > left) len = left;
                repeat (len)
                    send_tick(make_tick(heat, $urandom_range(0, 3) == 0, rand_temp()));
                left -= len;
            end
        end

        wait_idle();
        repeat (4) @(negedge clk);
        $display("sent %0d tick items (with a %0d-tick run at the largest click period), %0d register writes",
                 ticks_sent, SAT_RUN_TICKS, reg_writes);
        $display("compared %0d results, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
